// File: hdl/msbbr_pkg.sv
// shared types and constants of the msb-first bit reader
package msbbr_pkg;

	localparam int BUFFER_BYTES_DEF = 16;
	localparam int COUNT_W = 10;
	localparam int VALUE_W = 64;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_GET  = 3'd1,
		OP_PEEK = 3'd2,
		OP_SKIP = 3'd3,
		OP_GETS = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_OVER  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// one update of the bit window
	typedef struct packed {
		logic               push;
		logic [7:0]         byte_val;
		logic               consume;
		logic [COUNT_W-1:0] amount;
	} win_cmd_t;

endpackage

// File: hdl/msbbr_if.sv
// request and response channel interfaces
interface msbbr_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] byte_in;
	logic [9:0] bit_count;

	modport source (output valid, output operation, output byte_in, output bit_count,
		input ready);
	modport sink (input valid, input operation, input byte_in, input bit_count,
		output ready);
endinterface

interface msbbr_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;
	logic [7:0]  bits_skipped;
	logic [7:0]  bits_held;
	logic [31:0] bit_position;

	modport source (output valid, output value, output status, output bits_skipped,
		output bits_held, output bit_position, input ready);
	modport sink (input valid, input value, input status, input bits_skipped,
		input bits_held, input bit_position, output ready);
endinterface

// File: hdl/msb_first_bit_reader_unit.sv
// msb-first bit reader top level: request decode, window control, response register
// One request is taken per cycle, back to back, while responses are accepted. A request
// sits in the request register after its transfer; its response is registered once the
// response register is free or its response transfers. A field is extracted by a shift of
// the top 64 bits of the 8*BUFFER_BYTES-bit window, and the window shifts to consume it as
// the response is registered. While a response waits, the request register can still take
// one request, then requests stall until it transfers. No clearing pass runs after reset.
module msb_first_bit_reader_unit #(
	parameter int BUFFER_BYTES = msbbr_pkg::BUFFER_BYTES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	msbbr_req_if.sink    req,
	msbbr_rsp_if.source  rsp
);

	localparam int RING_BITS = 8 * BUFFER_BYTES;
	localparam int HELD_W = $clog2(RING_BITS + 1);
	localparam int CW = msbbr_pkg::COUNT_W;
	localparam int VW = msbbr_pkg::VALUE_W;

	logic          valid_s1;
	logic [2:0]    op_s1;
	logic [7:0]    byte_s1;
	logic [CW-1:0] count_s1;

	logic          rsp_valid_q;
	logic [VW-1:0] value_q;
	logic [1:0]    status_q;
	logic [7:0]    skipped_q;
	logic [7:0]    held_q;
	logic [31:0]   pos_q;
	logic [31:0]   consumed_q;

	logic                 advance;
	logic                 fire;
	msbbr_pkg::win_cmd_t  cmd;
	logic [VW-1:0]        head;
	logic [HELD_W-1:0]    held;
	logic [CW-1:0]        held_ext;
	logic [CW-1:0]        held_after;
	logic [VW-1:0]        value;
	logic [VW-1:0]        aligned;
	msbbr_pkg::status_t   status;
	logic [CW-1:0]        skipped;
	logic [6:0]           n7;
	logic [5:0]           sign_idx;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1    <= req.operation;
			byte_s1  <= req.byte_in;
			count_s1 <= req.bit_count;
		end
	end

	msbbr_window #(.BUFFER_BYTES(BUFFER_BYTES)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.held   (held)
	);

	assign held_ext = CW'(held);
	assign n7       = count_s1[6:0];
	assign sign_idx = count_s1[5:0] - 6'd1;
	// field of n bits taken from the top of the window
	assign aligned  = head >> (7'd64 - n7);

	always_comb begin
		cmd.push     = 1'b0;
		cmd.byte_val = byte_s1;
		cmd.consume  = 1'b0;
		cmd.amount   = '0;
		value        = '0;
		status       = msbbr_pkg::ST_OK;
		skipped      = '0;
		held_after   = held_ext;
		case (op_s1)
			msbbr_pkg::OP_PUSH: begin
				if (held_ext + CW'(8) > CW'(RING_BITS)) begin
					status = msbbr_pkg::ST_FULL;
				end else begin
					cmd.push   = fire;
					held_after = held_ext + CW'(8);
				end
			end
			msbbr_pkg::OP_GET, msbbr_pkg::OP_PEEK, msbbr_pkg::OP_GETS: begin
				if (count_s1 > CW'(64)) begin
					status = msbbr_pkg::ST_OVER;
				end else if (count_s1 > held_ext) begin
					status = msbbr_pkg::ST_SHORT;
				end else if (count_s1 != '0) begin
					value = aligned;
					if (op_s1 == msbbr_pkg::OP_GETS && count_s1 < CW'(64)
							&& aligned[sign_idx]) begin
						value = aligned | ({VW{1'b1}} << n7);
					end
					if (op_s1 != msbbr_pkg::OP_PEEK) begin
						cmd.consume = fire;
						cmd.amount  = count_s1;
						held_after  = held_ext - count_s1;
					end
				end
			end
			msbbr_pkg::OP_SKIP: begin
				skipped     = (count_s1 < held_ext) ? count_s1 : held_ext;
				cmd.consume = fire;
				cmd.amount  = skipped;
				held_after  = held_ext - skipped;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			consumed_q  <= '0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (cmd.consume) begin
				consumed_q <= consumed_q + 32'(cmd.amount);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			value_q   <= value;
			status_q  <= status;
			skipped_q <= skipped[7:0];
			held_q    <= held_after[7:0];
			pos_q     <= cmd.consume ? consumed_q + 32'(cmd.amount) : consumed_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.value        = value_q;
	assign rsp.status       = status_q;
	assign rsp.bits_skipped = skipped_q;
	assign rsp.bits_held    = held_q;
	assign rsp.bit_position = pos_q;

endmodule

// File: hdl/msbbr_window.sv
// left-aligned bit window: next unread bit sits at the msb
module msbbr_window #(
	parameter int BUFFER_BYTES = msbbr_pkg::BUFFER_BYTES_DEF,
	localparam int RING_BITS = 8 * BUFFER_BYTES,
	localparam int HELD_W = $clog2(RING_BITS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msbbr_pkg::win_cmd_t               cmd,
	output logic [msbbr_pkg::VALUE_W-1:0]     head,
	output logic [HELD_W-1:0]                 held
);

	logic [RING_BITS-1:0] win_q;
	logic [HELD_W-1:0]    held_q;
	logic [RING_BITS-1:0] ins;
	logic [RING_BITS-1:0] mask;

	// new byte lands right behind the last held bit
	assign ins  = {cmd.byte_val, {(RING_BITS - 8){1'b0}}} >> held_q;
	assign mask = {{8{1'b1}}, {(RING_BITS - 8){1'b0}}} >> held_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= (win_q & ~mask) | ins;
		end else if (cmd.consume) begin
			win_q <= win_q << cmd.amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.push) begin
			held_q <= held_q + HELD_W'(8);
		end else if (cmd.consume) begin
			held_q <= held_q - HELD_W'(cmd.amount);
		end
	end

	assign head = win_q[RING_BITS-1 -: msbbr_pkg::VALUE_W];
	assign held = held_q;

endmodule

// File: hdl/msbbr_checker.sv
// port-level checks of the bit reader and their binding
module msbbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_value,
	input logic [1:0]  rsp_status,
	input logic [7:0]  rsp_skipped,
	input logic [7:0]  rsp_held,
	input logic [31:0] rsp_position
);

	// stalled response keeps its whole payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
			&& $stable(rsp_status) && $stable(rsp_skipped) && $stable(rsp_held)
			&& $stable(rsp_position))
		else $error("response changed while stalled");

	// any error leaves value and skip count empty
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != msbbr_pkg::ST_OK |-> rsp_value == '0
			&& rsp_skipped == '0)
		else $error("error response carries data");

	// a skip that discarded bits is ok and returns no value
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_skipped != '0 |-> rsp_status == msbbr_pkg::ST_OK
			&& rsp_value == '0)
		else $error("skip response inconsistent");

endmodule

bind msb_first_bit_reader_unit msbbr_checker u_msbbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_value    (rsp.value),
	.rsp_status   (rsp.status),
	.rsp_skipped  (rsp.bits_skipped),
	.rsp_held     (rsp.bits_held),
	.rsp_position (rsp.bit_position)
);

// File: sim/tb_msb_first_bit_reader_unit.sv
// self-checking testbench of the msb-first bit reader unit
module tb_msb_first_bit_reader_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_BITS = msbbr_pkg::BUFFER_BYTES_DEF * 8;
	localparam int IDX_W = $clog2(msbbr_pkg::BUFFER_BYTES_DEF);
	localparam int RANDOM_ITEMS = 1300;
	localparam int PHASE_LEN = 450;
	localparam int HOLD_AT = 950;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 10;

	// codes the block must ignore
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] byte_val;
		logic [9:0] count;
	} bit_request_t;

	typedef struct packed {
		logic [63:0]         value;
		msbbr_pkg::status_t  status;
		logic [7:0]          skipped;
		logic [7:0]          held;
		logic [31:0]         position;
	} bit_reading_t;

	logic clk = 1'b0;
	logic arst_n;

	msbbr_req_if req_ch();
	msbbr_rsp_if rsp_ch();

	msb_first_bit_reader_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	bit_request_t pending_requests[$];
	bit_reading_t expected_readings[$];
	int requests_sent = 0;
	int readings_seen = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// shadow of the reader state
	logic [7:0] shadow_bytes [msbbr_pkg::BUFFER_BYTES_DEF];
	int shadow_rd = 0;
	int shadow_held = 0;
	logic [31:0] shadow_consumed = '0;

	// held-bit estimate used only to shape the stimulus
	int plan_held = 0;

	function automatic bit_reading_t predict_reading(bit_request_t r);
		bit_reading_t res;
		int wp;
		int p;
		int take;
		res = '0;
		res.status = msbbr_pkg::ST_OK;
		case (r.op)
			msbbr_pkg::OP_PUSH: begin
				if (shadow_held + 8 > RING_BITS) begin
					res.status = msbbr_pkg::ST_FULL;
				end else begin
					wp = (shadow_rd + shadow_held) % RING_BITS;
					shadow_bytes[IDX_W'(wp >> 3)] = r.byte_val;
					shadow_held += 8;
				end
			end
			msbbr_pkg::OP_GET, msbbr_pkg::OP_PEEK, msbbr_pkg::OP_GETS: begin
				if (r.count > 64) begin
					res.status = msbbr_pkg::ST_OVER;
				end else if (int'(r.count) > shadow_held) begin
					res.status = msbbr_pkg::ST_SHORT;
				end else if (r.count > 0) begin
					for (int i = 0; i < int'(r.count); i++) begin
						p = (shadow_rd + i) % RING_BITS;
						res.value = {res.value[62:0],
							shadow_bytes[IDX_W'(p >> 3)][3'(7 - (p & 7))]};
					end
					if (r.op == msbbr_pkg::OP_GETS && r.count < 64
							&& res.value[6'(r.count - 10'd1)])
						res.value |= ~64'd0 << r.count;
					if (r.op != msbbr_pkg::OP_PEEK) begin
						shadow_rd = (shadow_rd + int'(r.count)) % RING_BITS;
						shadow_held -= int'(r.count);
						shadow_consumed += 32'(r.count);
					end
				end
			end
			msbbr_pkg::OP_SKIP: begin
				take = (int'(r.count) < shadow_held) ? int'(r.count) : shadow_held;
				res.skipped = 8'(take);
				shadow_rd = (shadow_rd + take) % RING_BITS;
				shadow_held -= take;
				shadow_consumed += 32'(take);
			end
			default: begin
			end
		endcase
		res.held = 8'(shadow_held);
		res.position = shadow_consumed;
		return res;
	endfunction

	task automatic queue_request(logic [2:0] op, logic [7:0] b, logic [9:0] n);
		bit_request_t r;
		r.op = op;
		r.byte_val = b;
		r.count = n;
		pending_requests.push_back(r);
		if (op == msbbr_pkg::OP_PUSH && plan_held + 8 <= RING_BITS)
			plan_held += 8;
		else if ((op == msbbr_pkg::OP_GET || op == msbbr_pkg::OP_GETS) && n <= 64
				&& int'(n) <= plan_held)
			plan_held -= int'(n);
		else if (op == msbbr_pkg::OP_SKIP)
			plan_held -= (int'(n) < plan_held) ? int'(n) : plan_held;
	endtask

	function automatic logic [9:0] pick_count();
		int r;
		int top;
		r = $urandom_range(0, 9);
		top = (plan_held < 64) ? plan_held : 64;
		if (r == 0)
			return 10'($urandom_range(0, 1023));
		else if (r == 1)
			return 10'(plan_held + $urandom_range(1, 8));
		else
			return 10'($urandom_range(0, top));
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive
		int idle_pct;
		bit_request_t r;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= '0;
			req_ch.byte_in <= '0;
			req_ch.bit_count <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				r.op = req_ch.operation;
				r.byte_val = req_ch.byte_in;
				r.count = req_ch.bit_count;
				expected_readings.push_back(predict_reading(r));
				requests_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				idle_pct = (requests_sent < PHASE_LEN) ? 30 :
					(requests_sent < 2 * PHASE_LEN) ? 78 : 0;
				if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					r = pending_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= r.op;
					req_ch.byte_in <= r.byte_val;
					req_ch.bit_count <= r.count;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin : watch
		int idle_pct;
		bit_reading_t e;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				readings_seen++;
				if (expected_readings.size() == 0) begin
					$error("unexpected response transfer");
					mismatches++;
				end else begin
					e = expected_readings.pop_front();
					if (rsp_ch.value !== e.value) begin
						$error("value: expected %h got %h", e.value, rsp_ch.value);
						mismatches++;
					end
					if (rsp_ch.status !== e.status) begin
						$error("status: expected %0d got %0d", e.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.bits_skipped !== e.skipped) begin
						$error("bits_skipped: expected %0d got %0d", e.skipped,
							rsp_ch.bits_skipped);
						mismatches++;
					end
					if (rsp_ch.bits_held !== e.held) begin
						$error("bits_held: expected %0d got %0d", e.held, rsp_ch.bits_held);
						mismatches++;
					end
					if (rsp_ch.bit_position !== e.position) begin
						$error("bit_position: expected %0d got %0d", e.position,
							rsp_ch.bit_position);
						mismatches++;
					end
				end
			end
			idle_pct = (requests_sent < PHASE_LEN) ? 78 :
				(requests_sent < 2 * PHASE_LEN) ? 30 : 0;
			// one long back-pressure stretch so the unit fills and stalls requests
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && readings_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	initial begin : stimulus
		int quiet;
		int r;
		logic [2:0] op;
		arst_n = 1'b0;
		foreach (shadow_bytes[i])
			shadow_bytes[i] = '0;

		// directed: empty reads, fill to the brim, overflow, limits and sign cases
		queue_request(msbbr_pkg::OP_GET, 8'h00, 10'd1);
		queue_request(msbbr_pkg::OP_SKIP, 8'h00, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'hFF, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h00, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'hA5, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h80, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h01, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h7E, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'hC3, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h3C, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h80, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h7F, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'hFF, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'hFF, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h12, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h34, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h56, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'h78, 10'd0);
		queue_request(msbbr_pkg::OP_PUSH, 8'hEE, 10'd0);
		queue_request(msbbr_pkg::OP_PEEK, 8'h00, 10'd1023);
		queue_request(msbbr_pkg::OP_GET, 8'h00, 10'd65);
		queue_request(msbbr_pkg::OP_GET, 8'h00, 10'd0);
		queue_request(msbbr_pkg::OP_GETS, 8'h00, 10'd64);
		queue_request(msbbr_pkg::OP_GETS, 8'h00, 10'd7);
		queue_request(msbbr_pkg::OP_PEEK, 8'h00, 10'd9);
		queue_request(OP_RSVD5, 8'hFF, 10'd1023);
		queue_request(OP_RSVD7, 8'h00, 10'd0);
		queue_request(msbbr_pkg::OP_SKIP, 8'h00, 10'd1023);

		// random: mostly well-formed reads against what is held, some noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < ((plan_held <= 64) ? 55 : 30))
				queue_request(msbbr_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
					10'($urandom_range(0, 1023)));
			else if (r < 65)
				queue_request(msbbr_pkg::OP_GET, 8'($urandom_range(0, 255)), pick_count());
			else if (r < 75)
				queue_request(msbbr_pkg::OP_PEEK, 8'($urandom_range(0, 255)), pick_count());
			else if (r < 86)
				queue_request(msbbr_pkg::OP_GETS, 8'($urandom_range(0, 255)), pick_count());
			else if (r < 96)
				queue_request(msbbr_pkg::OP_SKIP, 8'($urandom_range(0, 255)), pick_count());
			else begin
				op = (r == 96) ? OP_RSVD5 : (r == 97) ? OP_RSVD6 : OP_RSVD7;
				queue_request(op, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		quiet = 0;
		while ((pending_requests.size() > 0 || req_ch.valid || expected_readings.size() > 0)
			&& quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end

		if (quiet >= WATCHDOG_LIMIT) begin
			$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (expected_readings.size() != 0)
				$error("%0d expected responses never arrived", expected_readings.size());
			if (mismatches == 0 && expected_readings.size() == 0)
				$display("[ OK ] regression clean");
			else
				$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
